@@ src/cmg_pkg.sv @@
`timescale 1ns / 1ps

package cmg_pkg;

  localparam int unsigned MaxSegments = 10;
  localparam int unsigned SegFloor    = 3;

  // Register indexes of the configuration port.
  typedef enum logic {
    CFG_SEG_COUNT = 1'b0,
    CFG_RADIUS    = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_LEN,
    OP_BASIS,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SQRT_SAVE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_SAVE,
    OP_CROSS_A,
    OP_CROSS_B,
    OP_CROSS_SAVE,
    OP_CORN_A,
    OP_CORN_B,
    OP_CORN_SUM,
    OP_CORN_RAD,
    OP_CORN_SAVE,
    OP_SHIFT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LEN,
    ST_BASIS,
    ST_DEGEN,
    ST_SQRT_INIT,
    ST_SQRT_STEP,
    ST_SQRT_SAVE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DIV_SAVE,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_CROSS_SAVE,
    ST_CORN_A,
    ST_CORN_B,
    ST_CORN_SUM,
    ST_CORN_RAD,
    ST_CORN_SAVE,
    ST_SHIFT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] sel;
    logic [3:0] corner;
    logic [2:0] vert;
    logic       blank;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_len;
  } dp_stat_t;

  localparam logic signed [15:0] COS_Q14 [8][10] = '{
    '{16384, -8192, -8192, 0, 0, 0, 0, 0, 0, 0},
    '{16384, 0, -16384, 0, 0, 0, 0, 0, 0, 0},
    '{16384, 5063, -13255, -13255, 5063, 0, 0, 0, 0, 0},
    '{16384, 8192, -8192, -16384, -8192, 8192, 0, 0, 0, 0},
    '{16384, 10215, -3646, -14761, -14761, -3646, 10215, 0, 0, 0},
    '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585, 0, 0},
    '{16384, 12551, 2845, -8192, -15396, -15396, -8192, 2845, 12551, 0},
    '{16384, 13255, 5063, -5063, -13255, -16384, -13255, -5063, 5063, 13255}
  };

  localparam logic signed [15:0] SIN_Q14 [8][10] = '{
    '{0, 14189, -14189, 0, 0, 0, 0, 0, 0, 0},
    '{0, 16384, 0, -16384, 0, 0, 0, 0, 0, 0},
    '{0, 15582, 9630, -9630, -15582, 0, 0, 0, 0, 0},
    '{0, 14189, 14189, 0, -14189, -14189, 0, 0, 0, 0},
    '{0, 12810, 15973, 7109, -7109, -15973, -12810, 0, 0, 0},
    '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585, 0, 0},
    '{0, 10531, 16135, 14189, 5604, -5604, -14189, -16135, -10531, 0},
    '{0, 9630, 15582, 15582, 9630, 0, -9630, -15582, -15582, -9630}
  };

  // Texture u of corner j for n slices: round(32768 * j / n).
  localparam logic [15:0] TEX_U [8][11] = '{
    '{0, 10923, 21845, 32768, 0, 0, 0, 0, 0, 0, 0},
    '{0, 8192, 16384, 24576, 32768, 0, 0, 0, 0, 0, 0},
    '{0, 6554, 13107, 19661, 26214, 32768, 0, 0, 0, 0, 0},
    '{0, 5461, 10923, 16384, 21845, 27307, 32768, 0, 0, 0, 0},
    '{0, 4681, 9362, 14043, 18725, 23406, 28087, 32768, 0, 0, 0},
    '{0, 4096, 8192, 12288, 16384, 20480, 24576, 28672, 32768, 0, 0},
    '{0, 3641, 7282, 10923, 14564, 18204, 21845, 25486, 29127, 32768, 0},
    '{0, 3277, 6554, 9830, 13107, 16384, 19661, 22938, 26214, 29491, 32768}
  };

  // Arithmetic shift right with rounding half away from zero.
  function automatic logic signed [95:0] round_shr(input logic signed [95:0] v,
                                                   input int unsigned sh);
    logic [95:0] mag;
    logic [95:0] q;
    mag = v[95] ? 96'(-v) : 96'(v);
    q   = (mag + (96'd1 << (sh - 1))) >> sh;
    return v[95] ? -$signed(q) : $signed(q);
  endfunction

endpackage

@@ src/cylinder_mesh_generator.sv @@
`timescale 1ns / 1ps
// Cylinder mesh generator: turns one segment into an open cylinder drawn as a
// triangle list, six vertices per radial slice.
// Input channel (in_valid_i/in_ready_o) carries the start and finish points;
// output channel (out_valid_o/out_ready_i) carries one vertex per transfer,
// with last_vertex_o high on the final vertex of the cylinder.
// The configuration port takes the slice count and the tube radius on any
// cycle with cfg_we_i high; write it only while no segment is in flight.
// A segment is taken only when the previous cylinder has been fully sent.
// The delay from the input transfer to the first vertex does not depend on
// the clamped slice count n; the remaining vertices then come at one per cycle
// within a slice while out_ready_i is high, with a pause between slices to
// build the next corner. The next segment can be taken in the cycle after the
// last vertex leaves. The pace is set by the reused bit-serial square root and
// divider (eight uses in all) and the shared multiplier.
// A zero-length segment gives one vertex with degenerate_o set, offered after
// the square, length and basis steps that follow the input transfer.
// A stalled receiver simply holds the current vertex; nothing is lost.
// Reset returns to idle with 8 slices and a radius of 256 coordinate units.

module cylinder_mesh_generator import cmg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] start_z_i,
  input  logic signed [15:0] finish_x_i,
  input  logic signed [15:0] finish_y_i,
  input  logic signed [15:0] finish_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0]        tex_u_o,
  output logic               tex_v_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               last_vertex_o,
  output logic               degenerate_o
);

  logic [3:0]  seg_count_q;
  logic [14:0] radius_q;
  logic [3:0]  seg_n;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= 4'd8;
      radius_q    <= 15'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SEG_COUNT: seg_count_q <= cfg_data_i[3:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i;
        default:       seg_count_q <= seg_count_q;
      endcase
    end
  end

  // Slice counts outside the supported range are pulled to the nearest end.
  assign seg_n = (seg_count_q < 4'(SegFloor))    ? 4'(SegFloor)    :
                 (seg_count_q > 4'(MaxSegments)) ? 4'(MaxSegments) : seg_count_q;

  cmg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seg_n_i       (seg_n),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_vertex_o (last_vertex_o),
    .degenerate_o  (degenerate_o),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  cmg_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .seg_n_i    (seg_n),
    .radius_i   (radius_q),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .start_z_i  (start_z_i),
    .finish_x_i (finish_x_i),
    .finish_y_i (finish_y_i),
    .finish_z_i (finish_z_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .tex_u_o    (tex_u_o),
    .tex_v_o    (tex_v_o),
    .norm_x_o   (norm_x_o),
    .norm_y_o   (norm_y_o),
    .norm_z_o   (norm_z_o)
  );

endmodule

@@ src/cmg_datapath.sv @@
`timescale 1ns / 1ps

module cmg_datapath import cmg_pkg::*; (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic [3:0]         seg_n_i,
  input  logic [14:0]        radius_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] start_z_i,
  input  logic signed [15:0] finish_x_i,
  input  logic signed [15:0] finish_y_i,
  input  logic signed [15:0] finish_z_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [15:0]        tex_u_o,
  output logic               tex_v_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o
);

  logic signed [15:0] p0_q [3];
  logic signed [15:0] p1_q [3];
  logic signed [16:0] a_q [3];
  logic signed [16:0] c_q [3];
  logic [32:0]        sq_q [3];
  logic [33:0]        len2_q;
  logic [33:0]        per2_q;
  logic [31:0]        sa_q, sc_q;
  logic [63:0]        sx_q, sr_q, sb_q;
  logic [63:0]        rem_q, dsr_q;
  logic [31:0]        quo_q;
  logic               neg_q;
  logic signed [32:0] rt_q [3];
  logic signed [32:0] dr_q [3];
  logic signed [32:0] fw_q [3];
  logic signed [65:0] pa_q, pb_q;
  logic signed [47:0] w_q;
  logic signed [63:0] rw_q;
  logic signed [15:0] cur_nrm_q [3];
  logic signed [15:0] nxt_nrm_q [3];
  logic signed [19:0] cur_off_q [3];
  logic signed [19:0] nxt_off_q [3];
  logic [15:0]        cur_u_q, nxt_u_q;

  logic [1:0]         k, i1, i2, s_m3;
  logic [2:0]         row;
  logic [3:0]         cidx;
  logic signed [15:0] cs, sn;
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] prod;
  logic signed [16:0] dv;
  logic [16:0]        dmag;
  logic [31:0]        dden;
  logic [63:0]        sq_try;
  logic [40:0]        lhs_up, rhs_up;
  logic               upx;
  logic signed [66:0] xdiff;
  logic signed [65:0] wsum;
  logic signed [95:0] nrm_r, off_r, fw_r;
  logic signed [15:0] rad_s;
  logic [32:0]        quo_s;

  assign k    = cmd_i.sel[1:0];
  assign i1   = (k == 2'd2) ? 2'd0 : k + 2'd1;
  assign i2   = (i1 == 2'd2) ? 2'd0 : i1 + 2'd1;
  assign s_m3 = 2'(cmd_i.sel - 3'd3);
  assign row  = 3'(seg_n_i - 4'(SegFloor));
  assign cidx = (cmd_i.corner == seg_n_i) ? 4'd0 : cmd_i.corner;
  assign cs   = COS_Q14[row][cidx];
  assign sn   = SIN_Q14[row][cidx];
  assign rad_s = $signed({1'b0, radius_i});

  assign stat_o.zero_len = (len2_q == '0);

  // Shared multiplier for the cross product and the corner vectors.
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (cmd_i.op)
      OP_CROSS_A: begin
        mul_x = rt_q[i1];
        mul_y = dr_q[i2];
      end
      OP_CROSS_B: begin
        mul_x = rt_q[i2];
        mul_y = dr_q[i1];
      end
      OP_CORN_A: begin
        mul_x = 33'(cs);
        mul_y = rt_q[k];
      end
      OP_CORN_B: begin
        mul_x = 33'(sn);
        mul_y = fw_q[k];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end
  assign prod = mul_x * mul_y;

  always_comb begin
    if (cmd_i.sel < 3'd3) begin
      dv   = c_q[k];
      dden = sc_q;
    end else begin
      dv   = a_q[s_m3];
      dden = sa_q;
    end
    dmag = dv[16] ? 17'(-dv) : 17'(dv);
  end

  assign sq_try = sr_q + sb_q;
  assign lhs_up = 41'(sq_q[1]) * 41'd100;
  assign rhs_up = 41'(len2_q) * 41'd81;
  assign upx    = lhs_up > rhs_up;
  assign xdiff  = 67'(pa_q) - 67'(pb_q);
  assign wsum   = pa_q + pb_q;
  assign fw_r   = round_shr(96'(xdiff), 30);
  assign nrm_r  = round_shr(96'(w_q), 30);
  assign off_r  = round_shr(96'(rw_q), 44);
  assign quo_s  = {1'b0, quo_q};

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        p0_q[0] <= start_x_i;
        p0_q[1] <= start_y_i;
        p0_q[2] <= start_z_i;
        p1_q[0] <= finish_x_i;
        p1_q[1] <= finish_y_i;
        p1_q[2] <= finish_z_i;
        a_q[0]  <= 17'(finish_x_i) - 17'(start_x_i);
        a_q[1]  <= 17'(finish_y_i) - 17'(start_y_i);
        a_q[2]  <= 17'(finish_z_i) - 17'(start_z_i);
      end
      OP_SQUARE: begin
        for (int j = 0; j < 3; j++) begin
          sq_q[j] <= 33'(34'(a_q[j] * a_q[j]));
        end
      end
      OP_LEN: begin
        len2_q <= 34'(sq_q[0]) + 34'(sq_q[1]) + 34'(sq_q[2]);
      end
      OP_BASIS: begin
        // Helper up vector is the x axis when the axis is mostly along y.
        if (upx) begin
          c_q[0] <= '0;
          c_q[1] <= a_q[2];
          c_q[2] <= -a_q[1];
          per2_q <= 34'(sq_q[2]) + 34'(sq_q[1]);
        end else begin
          c_q[0] <= -a_q[2];
          c_q[1] <= '0;
          c_q[2] <= a_q[0];
          per2_q <= 34'(sq_q[2]) + 34'(sq_q[0]);
        end
      end
      OP_SQRT_INIT: begin
        sx_q <= (cmd_i.sel[0] ? 64'(per2_q) : 64'(len2_q)) << 24;
        sr_q <= '0;
        sb_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sx_q >= sq_try) begin
          sx_q <= sx_q - sq_try;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_SQRT_SAVE: begin
        if (cmd_i.sel[0]) begin
          sc_q <= sr_q[31:0];
        end else begin
          sa_q <= sr_q[31:0];
        end
      end
      OP_DIV_INIT: begin
        rem_q <= (64'(dmag) << 42) + 64'(dden[31:1]);
        dsr_q <= {1'b0, dden, 31'b0};
        quo_q <= '0;
        neg_q <= dv[16];
      end
      OP_DIV_STEP: begin
        if (rem_q >= dsr_q) begin
          rem_q <= rem_q - dsr_q;
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          quo_q <= {quo_q[30:0], 1'b0};
        end
        dsr_q <= dsr_q >> 1;
      end
      OP_DIV_SAVE: begin
        if (cmd_i.sel < 3'd3) begin
          rt_q[k] <= neg_q ? -$signed(quo_s) : $signed(quo_s);
        end else begin
          dr_q[s_m3] <= neg_q ? -$signed(quo_s) : $signed(quo_s);
        end
      end
      OP_CROSS_A, OP_CORN_A: begin
        pa_q <= prod;
      end
      OP_CROSS_B, OP_CORN_B: begin
        pb_q <= prod;
      end
      OP_CROSS_SAVE: begin
        fw_q[k] <= fw_r[32:0];
      end
      OP_CORN_SUM: begin
        w_q <= wsum[47:0];
      end
      OP_CORN_RAD: begin
        rw_q <= rad_s * w_q;
      end
      OP_CORN_SAVE: begin
        if (nrm_r > 96'sd16384) begin
          nxt_nrm_q[k] <= 16'sd16384;
        end else if (nrm_r < -96'sd16384) begin
          nxt_nrm_q[k] <= -16'sd16384;
        end else begin
          nxt_nrm_q[k] <= nrm_r[15:0];
        end
        nxt_off_q[k] <= off_r[19:0];
        nxt_u_q      <= TEX_U[row][cmd_i.corner];
      end
      OP_SHIFT: begin
        cur_nrm_q <= nxt_nrm_q;
        cur_off_q <= nxt_off_q;
        cur_u_q   <= nxt_u_q;
      end
      default: begin
      end
    endcase
  end

  // Vertex order within a slice: corners i, i, i+1, i, i+1, i+1 with
  // the finish point on the second, third and fifth vertex.
  logic               use_nxt, at_finish;
  logic signed [20:0] psum [3];
  logic signed [15:0] pos [3];
  logic signed [15:0] nrm [3];

  always_comb begin
    case (cmd_i.vert)
      3'd2, 3'd4, 3'd5: use_nxt = 1'b1;
      default:          use_nxt = 1'b0;
    endcase
    case (cmd_i.vert)
      3'd1, 3'd2, 3'd4: at_finish = 1'b1;
      default:          at_finish = 1'b0;
    endcase
    for (int j = 0; j < 3; j++) begin
      psum[j] = 21'(at_finish ? p1_q[j] : p0_q[j])
              + 21'(use_nxt ? nxt_off_q[j] : cur_off_q[j]);
      if (psum[j] > 21'sd32767) begin
        pos[j] = 16'sd32767;
      end else if (psum[j] < -21'sd32768) begin
        pos[j] = -16'sd32768;
      end else begin
        pos[j] = psum[j][15:0];
      end
      nrm[j] = use_nxt ? nxt_nrm_q[j] : cur_nrm_q[j];
      if (cmd_i.blank) begin
        pos[j] = '0;
        nrm[j] = '0;
      end
    end
  end

  assign pos_x_o  = pos[0];
  assign pos_y_o  = pos[1];
  assign pos_z_o  = pos[2];
  assign norm_x_o = nrm[0];
  assign norm_y_o = nrm[1];
  assign norm_z_o = nrm[2];
  assign tex_u_o  = cmd_i.blank ? 16'd0 : (use_nxt ? nxt_u_q : cur_u_q);
  assign tex_v_o  = cmd_i.blank ? 1'b0 : at_finish;

endmodule

@@ src/cmg_ctrl.sv @@
`timescale 1ns / 1ps

module cmg_ctrl import cmg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] seg_n_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       last_vertex_o,
  output logic       degenerate_o,
  output dp_cmd_t    cmd_o,
  input  dp_stat_t   stat_i
);

  ctrl_state_e state_q, state_d;
  logic [2:0]  idx_q, idx_d;
  logic [4:0]  step_q, step_d;
  logic [3:0]  corner_q, corner_d;
  logic [2:0]  vert_q, vert_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      step_q   <= '0;
      corner_q <= '0;
      vert_q   <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
      corner_q <= corner_d;
      vert_q   <= vert_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    step_d   = step_q;
    corner_d = corner_q;
    vert_d   = vert_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_LEN;
      ST_LEN:    state_d = ST_BASIS;
      ST_BASIS: begin
        idx_d   = '0;
        state_d = stat_i.zero_len ? ST_DEGEN : ST_SQRT_INIT;
      end
      ST_DEGEN:  if (out_ready_i) state_d = ST_IDLE;
      ST_SQRT_INIT: begin
        step_d  = '0;
        state_d = ST_SQRT_STEP;
      end
      ST_SQRT_STEP: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) state_d = ST_SQRT_SAVE;
      end
      ST_SQRT_SAVE: begin
        if (idx_q == 3'd1) begin
          idx_d   = '0;
          state_d = ST_DIV_INIT;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_SQRT_INIT;
        end
      end
      ST_DIV_INIT: begin
        step_d  = '0;
        state_d = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) state_d = ST_DIV_SAVE;
      end
      ST_DIV_SAVE: begin
        if (idx_q == 3'd5) begin
          idx_d   = '0;
          state_d = ST_CROSS_A;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_CROSS_A: state_d = ST_CROSS_B;
      ST_CROSS_B: state_d = ST_CROSS_SAVE;
      ST_CROSS_SAVE: begin
        if (idx_q == 3'd2) begin
          idx_d    = '0;
          corner_d = '0;
          state_d  = ST_CORN_A;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_CROSS_A;
        end
      end
      ST_CORN_A:   state_d = ST_CORN_B;
      ST_CORN_B:   state_d = ST_CORN_SUM;
      ST_CORN_SUM: state_d = ST_CORN_RAD;
      ST_CORN_RAD: state_d = ST_CORN_SAVE;
      ST_CORN_SAVE: begin
        if (idx_q != 3'd2) begin
          idx_d   = idx_q + 3'd1;
          state_d = ST_CORN_A;
        end else if (corner_q == '0) begin
          state_d = ST_SHIFT;
        end else begin
          vert_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_SHIFT: begin
        idx_d    = '0;
        corner_d = corner_q + 4'd1;
        state_d  = ST_CORN_A;
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (vert_q == 3'd5) begin
            state_d = (corner_q == seg_n_i) ? ST_IDLE : ST_SHIFT;
          end else begin
            vert_d = vert_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.sel    = idx_q;
    cmd_o.corner = corner_q;
    cmd_o.vert   = vert_q;
    cmd_o.blank  = 1'b0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    last_vertex_o = 1'b0;
    degenerate_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_SQUARE:     cmd_o.op = OP_SQUARE;
      ST_LEN:        cmd_o.op = OP_LEN;
      ST_BASIS:      cmd_o.op = OP_BASIS;
      ST_DEGEN: begin
        cmd_o.blank   = 1'b1;
        out_valid_o   = 1'b1;
        last_vertex_o = 1'b1;
        degenerate_o  = 1'b1;
      end
      ST_SQRT_INIT:  cmd_o.op = OP_SQRT_INIT;
      ST_SQRT_STEP:  cmd_o.op = OP_SQRT_STEP;
      ST_SQRT_SAVE:  cmd_o.op = OP_SQRT_SAVE;
      ST_DIV_INIT:   cmd_o.op = OP_DIV_INIT;
      ST_DIV_STEP:   cmd_o.op = OP_DIV_STEP;
      ST_DIV_SAVE:   cmd_o.op = OP_DIV_SAVE;
      ST_CROSS_A:    cmd_o.op = OP_CROSS_A;
      ST_CROSS_B:    cmd_o.op = OP_CROSS_B;
      ST_CROSS_SAVE: cmd_o.op = OP_CROSS_SAVE;
      ST_CORN_A:     cmd_o.op = OP_CORN_A;
      ST_CORN_B:     cmd_o.op = OP_CORN_B;
      ST_CORN_SUM:   cmd_o.op = OP_CORN_SUM;
      ST_CORN_RAD:   cmd_o.op = OP_CORN_RAD;
      ST_CORN_SAVE:  cmd_o.op = OP_CORN_SAVE;
      ST_SHIFT:      cmd_o.op = OP_SHIFT;
      ST_EMIT: begin
        out_valid_o   = 1'b1;
        last_vertex_o = (corner_q == seg_n_i) && (vert_q == 3'd5);
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule
